>>> rtl/fat_short_name_decoder_core_assert.svh
// Assertion macros for the short-name decoder RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef FAT_SHORT_NAME_DECODER_CORE_ASSERT_SVH
`define FAT_SHORT_NAME_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define FSND_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FSND_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/fsnd_pkg.sv
// Types, constants and helpers for the FAT short-name decoder.
// No dependencies.
package fsnd_pkg;

    localparam int NAME_LEN    = 8;
    localparam int EXT_LEN     = 3;
    localparam int MAX_RESULTS = NAME_LEN + 1 + EXT_LEN + 1;

    localparam int NAME_CNT_W = $clog2(NAME_LEN + 1);
    localparam int EXT_CNT_W  = $clog2(EXT_LEN + 1);
    localparam int IDX_W      = $clog2(MAX_RESULTS);

    localparam int ENTRY_W = 8 * NAME_LEN + 8 * EXT_LEN + 8;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CHAR_NUL       = 8'h00;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_DOT       = 8'h2E;
    localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CASE_OFFSET    = 8'd32;
    localparam logic [7:0] MARK_DELETED   = 8'hE5;
    localparam logic [7:0] ATTR_LONG_NAME = 8'h0F;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_DELETED = 2'd2,
        ST_LONG    = 2'd3
    } status_t;

    typedef struct packed {
        logic [8*NAME_LEN-1:0] name_bytes;
        logic [8*EXT_LEN-1:0]  ext_bytes;
        logic [NAME_CNT_W-1:0] name_len;
        logic [EXT_CNT_W-1:0]  ext_len;
        logic                  has_ext;
        logic [IDX_W-1:0]      last_idx;
        status_t               status;
    } desc_t;

    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

endpackage

>>> rtl/fsnd_front.sv
// Front end: registers one directory entry and classifies it into a descriptor.
// Depends on fsnd_pkg.
module fsnd_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [fsnd_pkg::ENTRY_W-1:0] s_tdata,
    output logic                        push_valid,
    input  logic                        push_ready,
    output fsnd_pkg::desc_t             push_desc
);
    import fsnd_pkg::*;

    logic               ent_vld_reg;
    logic               ent_vld_next;
    logic [ENTRY_W-1:0] ent_reg;

    logic [8*NAME_LEN-1:0] name_w;
    logic [8*EXT_LEN-1:0]  ext_w;
    logic [7:0]            attr_w;
    logic [NAME_CNT_W-1:0] name_len;
    logic [EXT_CNT_W-1:0]  ext_len;
    logic                  has_ext;
    status_t               status;
    logic [IDX_W-1:0]      last_idx;

    assign s_tready = !ent_vld_reg || push_ready;

    always_comb
    begin
        ent_vld_next = ent_vld_reg;
        if (s_tready)
        begin
            ent_vld_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_vld_reg <= 1'b0;
        end
        else
        begin
            ent_vld_reg <= ent_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            ent_reg <= s_tdata;
        end
    end

    assign name_w = ent_reg[8*NAME_LEN-1:0];
    assign ext_w  = ent_reg[8*NAME_LEN +: 8*EXT_LEN];
    assign attr_w = ent_reg[ENTRY_W-1 -: 8];

    // first space wins
    always_comb
    begin
        name_len = NAME_CNT_W'(NAME_LEN);
        for (int j = NAME_LEN - 1; j >= 0; j--)
        begin
            if (name_w[8*j +: 8] == CHAR_SPACE)
            begin
                name_len = NAME_CNT_W'(j);
            end
        end
        ext_len = EXT_CNT_W'(EXT_LEN);
        for (int j = EXT_LEN - 1; j >= 0; j--)
        begin
            if (ext_w[8*j +: 8] == CHAR_SPACE)
            begin
                ext_len = EXT_CNT_W'(j);
            end
        end
    end

    always_comb
    begin
        has_ext = (ext_w[7:0] != CHAR_SPACE);
        if (name_w[7:0] == CHAR_NUL)
        begin
            status = ST_EMPTY;
        end
        else if (name_w[7:0] == MARK_DELETED)
        begin
            status = ST_DELETED;
        end
        else if ((attr_w & ATTR_LONG_NAME) == ATTR_LONG_NAME)
        begin
            status = ST_LONG;
        end
        else
        begin
            status = ST_OK;
        end

        if (status != ST_OK)
        begin
            last_idx = '0;
        end
        else if (has_ext)
        begin
            last_idx = IDX_W'(name_len) + IDX_W'(ext_len) + IDX_W'(1);
        end
        else
        begin
            last_idx = IDX_W'(name_len);
        end
    end

    assign push_valid           = ent_vld_reg;
    assign push_desc.name_bytes = name_w;
    assign push_desc.ext_bytes  = ext_w;
    assign push_desc.name_len   = name_len;
    assign push_desc.ext_len    = ext_len;
    assign push_desc.has_ext    = has_ext;
    assign push_desc.last_idx   = last_idx;
    assign push_desc.status     = status;

endmodule

>>> rtl/fsnd_queue.sv
// Short descriptor queue between front end and character sequencer.
// Depends on fsnd_pkg.
module fsnd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  fsnd_pkg::desc_t push_desc,
    output logic            pop_valid,
    input  logic            pop,
    output fsnd_pkg::desc_t pop_desc
);
    import fsnd_pkg::*;

    desc_t              slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg;
    logic [Q_CNT_W-1:0] cnt_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (cnt_reg != Q_CNT_W'(Q_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_desc   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

>>> rtl/fsnd_back.sv
// Back end: walks a descriptor into the output register, one character per cycle unless stalled.
// Depends on fsnd_pkg and the assertion macro header.
`include "fat_short_name_decoder_core_assert.svh"
module fsnd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            desc_valid,
    input  fsnd_pkg::desc_t desc,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,   // character
    output logic            m_tlast,   // last_flag
    output logic [1:0]      m_tuser    // status
);
    import fsnd_pkg::*;

    logic             out_vld_reg;
    logic             out_vld_next;
    logic [7:0]       char_reg;
    logic             last_reg;
    status_t          status_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    logic             load;
    logic             is_last;
    logic [7:0]       char_sel;
    logic [IDX_W-1:0] ext_off;

    assign load    = desc_valid && (!out_vld_reg || m_tready);
    assign is_last = (idx_reg == desc.last_idx);
    assign pop     = load && is_last;
    assign ext_off = idx_reg - IDX_W'(desc.name_len) - IDX_W'(1);

    always_comb
    begin
        char_sel = CHAR_NUL;
        if (desc.status != ST_OK)
        begin
            char_sel = CHAR_NUL;
        end
        else if (idx_reg < IDX_W'(desc.name_len))
        begin
            char_sel = fold_lower(desc.name_bytes[8*idx_reg[2:0] +: 8]);
        end
        else if (desc.has_ext && idx_reg == IDX_W'(desc.name_len))
        begin
            char_sel = CHAR_DOT;
        end
        else if (desc.has_ext && ext_off < IDX_W'(desc.ext_len))
        begin
            case (ext_off[EXT_CNT_W-1:0])
                2'd0:    char_sel = fold_lower(desc.ext_bytes[7:0]);
                2'd1:    char_sel = fold_lower(desc.ext_bytes[15:8]);
                default: char_sel = fold_lower(desc.ext_bytes[23:16]);
            endcase
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        idx_next     = idx_reg;
        if (load)
        begin
            out_vld_next = 1'b1;
            idx_next     = is_last ? '0 : idx_reg + 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg   <= char_sel;
            last_reg   <= is_last;
            status_reg <= desc.status;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = status_reg;

    `FSND_ASSERT_NOW(a_reject_single, m_tvalid && status_reg != ST_OK, m_tlast && m_tdata == CHAR_NUL, "rejected entry word not a lone NUL")
    `FSND_ASSERT_NOW(a_idx_range, 1'b1, idx_reg < IDX_W'(MAX_RESULTS), "character index past max")
    `FSND_ASSERT_NOW(a_mid_entry_desc, idx_reg != '0, desc_valid, "descriptor lost mid entry")
    `FSND_ASSERT_NEXT(a_restart, pop, idx_reg == '0, "index not rewound after entry")

endmodule

>>> rtl/fat_short_name_decoder_core.sv
// FAT 8.3 short-name decoder, top level.
// Channels: s_* takes one directory entry per word, m_* returns one name character per word.
// Input word is 96 bits: name bytes, extension bytes, attribute byte.
// Output: tdata is the character, tlast ends the entry, tuser is the status code.
// A rejected entry (empty, deleted, long-name) yields a single NUL word with its status.
// A valid entry yields name chars, optional dot and extension chars, then a NUL with tlast.
// The first character goes through the entry register, a queue slot and the output register.
// Throughput: one output word per cycle unless stalled; an entry yields 1 to 13 words,
// set by the character sequencer that walks each entry one position per cycle unless stalled.
// Entries are taken back to back while the two-deep descriptor queue has room.
// When the receiver stalls, the output word holds and the queue and front fill,
// then s_tready drops. Reset empties all stages; no state is kept between entries.
module fat_short_name_decoder_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [fsnd_pkg::ENTRY_W-1:0] s_tdata,   // name_bytes, ext_bytes, attributes
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,   // character
    output logic                         m_tlast,   // last_flag
    output logic [1:0]                   m_tuser    // status
);
    import fsnd_pkg::*;

    logic  push_valid;
    logic  push_ready;
    desc_t push_desc;
    logic  pop_valid;
    logic  pop;
    desc_t pop_desc;

    fsnd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc)
    );

    fsnd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_desc   (pop_desc)
    );

    fsnd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (pop_valid),
        .desc       (pop_desc),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule
